@@ sv/ir2r_pkg.sv @@
// Shared types and constants for the impedance to component extraction pipeline.
`default_nettype none

package ir2r_pkg;

  typedef enum logic [1:0] {
    KIND_RESISTOR  = 2'd0,
    KIND_INDUCTOR  = 2'd1,
    KIND_CAPACITOR = 2'd2
  } kind_t;

  localparam logic CFG_PHASE_THRESHOLD = 1'b0;
  localparam logic CFG_TEST_FREQUENCY  = 1'b1;

  localparam logic [14:0] THRESHOLD_RESET = 15'd6390;
  localparam logic [19:0] FREQUENCY_RESET = 20'd1000;

  // Width of the rotation datapath (x, y and rest angle, Q30).
  localparam int XW = 34;

  localparam logic signed [XW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [33:0]          TWO_PI_Q30  = 34'd6746518852;
  localparam logic [34:0]          TWO_PI_Q32  = 35'd26986075409;

  localparam int DEN_W = 55;

  localparam logic [63:0] IND_SCALE  = 64'd4000000000000;
  localparam logic [63:0] CAP_NUM_HI = 64'd250000000000000000;

  // Divisor width: 2*pi*f times the reactance stays below 2^117.
  localparam int DIV_W = 118;
  localparam int QUO_W = 64;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Per-request values that travel down the pipeline beside the datapath.
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        mag;
    logic signed [32:0] res;
    logic signed [32:0] stray;
    logic               wrong;
    logic               zero;
    logic               ovf;
  } side_t;

endpackage

`default_nettype wire

@@ sv/ir2r_cordic.sv @@
// Angle reduction and pipelined CORDIC rotation producing clamped cosine and sine.
`default_nettype none

module ir2r_cordic #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STAGES   = 24
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       adv,
  input  wire                       in_valid,
  input  wire ir2r_pkg::side_t      in_side,
  input  wire logic signed [15:0]   in_phase,
  output logic                      out_valid,
  output ir2r_pkg::side_t           out_side,
  output logic signed [31:0]        out_cos,
  output logic signed [31:0]        out_sin
);

  localparam int XW    = ir2r_pkg::XW;
  localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam int MW    = 46 - ANGLE_FRAC_BITS;
  localparam int RK    = (MW > 32) ? (MW - 32) : 1;
  localparam int FW    = 36;

  localparam logic signed [FW-1:0] F_PI      = 36'sd3373259426;
  localparam logic signed [FW-1:0] F_HALF_PI = 36'sd1686629713;
  localparam logic signed [FW-1:0] F_TWO_PI  = 36'sd6746518852;

  // Reduction stage: truncating remainder of 2*pi on the magnitude.
  logic                  red_v_r;
  ir2r_pkg::side_t       red_side_r;
  logic signed [34:0]    red_z_r, red_z_nxt;
  logic [15:0]           ph_abs;
  logic [63:0]           m;
  logic [34:0]           m_ext;

  always_comb begin
    ph_abs = in_phase[15] ? (~in_phase + 16'd1) : in_phase;
    m      = {48'b0, ph_abs} << SHIFT;
    for (int k = RK - 1; k >= 0; k--) begin
      if (m >= ({30'b0, ir2r_pkg::TWO_PI_Q30} << k)) begin
        m = m - ({30'b0, ir2r_pkg::TWO_PI_Q30} << k);
      end
    end
    m_ext     = {1'b0, m[33:0]};
    red_z_nxt = in_phase[15] ? -$signed(m_ext) : $signed(m_ext);
  end

  // Rotation chain; entry 0 is written by the fold stage.
  logic                  v_r    [CORDIC_STAGES+1];
  ir2r_pkg::side_t       side_r [CORDIC_STAGES+1];
  logic                  neg_r  [CORDIC_STAGES+1];
  logic signed [XW-1:0]  x_r    [CORDIC_STAGES+1];
  logic signed [XW-1:0]  y_r    [CORDIC_STAGES+1];
  logic signed [XW-1:0]  z_r    [CORDIC_STAGES+1];

  logic signed [FW-1:0]  fz;
  logic                  fneg;

  always_comb begin
    fz   = FW'(red_z_r);
    fneg = 1'b0;
    if (fz > F_PI) begin
      fz = fz - F_TWO_PI;
    end else if (fz < -F_PI) begin
      fz = fz + F_TWO_PI;
    end
    if (fz > F_HALF_PI) begin
      fz   = fz - F_PI;
      fneg = 1'b1;
    end else if (fz < -F_HALF_PI) begin
      fz   = fz + F_PI;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r <= 1'b0;
      v_r[0]  <= 1'b0;
    end else if (adv) begin
      red_v_r <= in_valid;
      v_r[0]  <= red_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_side_r <= in_side;
      red_z_r    <= red_z_nxt;
      side_r[0]  <= red_side_r;
      neg_r[0]   <= fneg;
      x_r[0]     <= ir2r_pkg::CORDIC_GAIN;
      y_r[0]     <= '0;
      z_r[0]     <= XW'(fz);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] ang;
    logic signed [XW-1:0] x_nxt, y_nxt, z_nxt;

    always_comb begin
      ang = $signed({{(XW-32){1'b0}}, ir2r_pkg::ATAN_Q30[i]});
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - ang;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i+1] <= side_r[i];
        neg_r[i+1]  <= neg_r[i];
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
      end
    end
  end

  // Undo the half-turn fold, then clamp to [-1, 1].
  logic signed [XW-1:0] xf, yf;
  logic signed [31:0]   cos_nxt, sin_nxt;
  logic                 out_v_r;
  ir2r_pkg::side_t      out_side_r;
  logic signed [31:0]   cos_r, sin_r;

  always_comb begin
    xf = neg_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
    yf = neg_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
    if (xf > ir2r_pkg::Q30_ONE) xf = ir2r_pkg::Q30_ONE;
    if (xf < -ir2r_pkg::Q30_ONE) xf = -ir2r_pkg::Q30_ONE;
    if (yf > ir2r_pkg::Q30_ONE) yf = ir2r_pkg::Q30_ONE;
    if (yf < -ir2r_pkg::Q30_ONE) yf = -ir2r_pkg::Q30_ONE;
    cos_nxt = 32'(xf);
    sin_nxt = 32'(yf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side_r <= side_r[CORDIC_STAGES];
      cos_r      <= cos_nxt;
      sin_r      <= sin_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_side  = out_side_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

endmodule

`default_nettype wire

@@ sv/ir2r_mul64.sv @@
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 by 32 partial products.
`default_nettype none

module ir2r_mul64 (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   in_valid,
  input  wire ir2r_pkg::side_t  in_side,
  input  wire logic [63:0]      in_a,
  input  wire logic [63:0]      in_b,
  output logic                  out_valid,
  output ir2r_pkg::side_t       out_side,
  output logic [127:0]          out_prod
);

  logic            p_v_r, s_v_r;
  ir2r_pkg::side_t p_side_r, s_side_r;
  logic [63:0]     p00_r, p01_r, p10_r, p11_r;
  logic [127:0]    prod_r, prod_nxt;

  always_comb begin
    prod_nxt = {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
             + {p11_r, 64'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_valid;
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_side_r <= in_side;
      p00_r    <= in_a[31:0]  * in_b[31:0];
      p01_r    <= in_a[31:0]  * in_b[63:32];
      p10_r    <= in_a[63:32] * in_b[31:0];
      p11_r    <= in_a[63:32] * in_b[63:32];
      s_side_r <= p_side_r;
      prod_r   <= prod_nxt;
    end
  end

  assign out_valid = s_v_r;
  assign out_side  = s_side_r;
  assign out_prod  = prod_r;

endmodule

`default_nettype wire

@@ sv/ir2r_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for quotients below 2^64.
`default_nettype none

module ir2r_div (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  adv,
  input  wire                                  in_valid,
  input  wire ir2r_pkg::side_t                 in_side,
  input  wire logic [127:0]                    in_num,
  input  wire logic [ir2r_pkg::DIV_W-1:0]      in_den,
  output logic                                 out_valid,
  output ir2r_pkg::side_t                      out_side,
  output logic [ir2r_pkg::QUO_W-1:0]           out_quo
);

  localparam int DW = ir2r_pkg::DIV_W;
  localparam int QW = ir2r_pkg::QUO_W;

  logic            v_r    [QW+1];
  ir2r_pkg::side_t side_r [QW+1];
  logic [DW-1:0]   rem_r  [QW+1];
  logic [DW-1:0]   den_r  [QW+1];
  logic [QW-1:0]   lo_r   [QW+1];
  logic [QW-1:0]   quo_r  [QW+1];

  // The upper half of the numerator is the starting remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      rem_r[0]  <= DW'(in_num[127:64]);
      den_r[0]  <= in_den;
      lo_r[0]   <= in_num[63:0];
      quo_r[0]  <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0]   trial;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    always_comb begin
      trial = {rem_r[i], lo_r[i][QW-1]};
      if (trial >= {1'b0, den_r[i]}) begin
        rem_nxt = DW'(trial - {1'b0, den_r[i]});
        quo_nxt = {quo_r[i][QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[i][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= rem_nxt;
        den_r[i+1]  <= den_r[i];
        lo_r[i+1]   <= {lo_r[i][QW-2:0], 1'b0};
        quo_r[i+1]  <= quo_nxt;
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_side  = side_r[QW];
  assign out_quo   = quo_r[QW];

endmodule

`default_nettype wire

@@ sv/impedance_to_rlc_component.sv @@
// Top level: polar impedance in, series resistance and L or C value out.
`default_nettype none

// Takes one impedance request per clock and returns one result per request, in order.
// The path is a fully pipelined chain: angle reduction, one register stage per CORDIC
// rotation, a 33 by 32 bit multiply, a 64 by 64 bit multiply split into four partial
// products, and a 64-stage restoring divider that forms one quotient bit per stage. The
// whole chain advances together; it holds only while a result waits at the output and
// out_stall is high, and in_stall is high exactly then. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while no request is in
// flight, as the block itself does not enforce this.
module impedance_to_rlc_component #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STAGES   = 24
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire logic [31:0]   in_impedance_magnitude,
  input  wire logic signed [15:0] in_phase_angle,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         out_component_kind,
  output logic signed [32:0] out_series_resistance,
  output logic signed [32:0] out_stray_reactance,
  output logic [63:0]        out_reactive_value,
  output logic               out_value_saturated,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire logic [19:0]   cfg_wdata
);

  localparam int DEN_W = ir2r_pkg::DEN_W;
  localparam int DW    = ir2r_pkg::DIV_W;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Configuration registers and the derived 2*pi*f.
  logic [14:0]      thr_r;
  logic [19:0]      freq_r;
  logic [DEN_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ir2r_pkg::THRESHOLD_RESET;
      freq_r <= ir2r_pkg::FREQUENCY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ir2r_pkg::CFG_PHASE_THRESHOLD: thr_r  <= cfg_wdata[14:0];
        ir2r_pkg::CFG_TEST_FREQUENCY:  freq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    den_r <= DEN_W'(ir2r_pkg::TWO_PI_Q32 * freq_r);
  end

  // Classification at entry.
  ir2r_pkg::side_t  entry_side;
  logic signed [16:0] ph_ext, thr_ext;

  always_comb begin
    ph_ext           = 17'(in_phase_angle);
    thr_ext          = $signed({2'b0, thr_r});
    entry_side       = '0;
    entry_side.mag   = in_impedance_magnitude;
    if (ph_ext < -thr_ext) begin
      entry_side.kind = ir2r_pkg::KIND_CAPACITOR;
    end else if (ph_ext > thr_ext) begin
      entry_side.kind = ir2r_pkg::KIND_INDUCTOR;
    end else begin
      entry_side.kind = ir2r_pkg::KIND_RESISTOR;
    end
  end

  logic               cor_v;
  ir2r_pkg::side_t    cor_side;
  logic signed [31:0] cor_cos, cor_sin;

  ir2r_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STAGES   (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_side   (entry_side),
    .in_phase  (in_phase_angle),
    .out_valid (cor_v),
    .out_side  (cor_side),
    .out_cos   (cor_cos),
    .out_sin   (cor_sin)
  );

  // Rectangular products in milliohm * 2^-30.
  logic               mul_v_r;
  ir2r_pkg::side_t    mul_side_r;
  logic signed [63:0] pr_r, pi_r, pr_nxt, pi_nxt;

  always_comb begin
    pr_nxt = $signed({1'b0, cor_side.mag}) * cor_cos;
    pi_nxt = $signed({1'b0, cor_side.mag}) * cor_sin;
  end

  // Rounding, sign check and multiplier operand selection.
  logic               rnd_v_r;
  ir2r_pkg::side_t    rnd_side_r, rnd_side_nxt;
  logic [63:0]        ap_r, ap_nxt, opb_r, opb_nxt;
  logic [63:0]        rm_abs, ri_abs, rm_sum, ri_sum;
  logic [32:0]        rm_q, ri_q;

  always_comb begin
    rm_abs = pr_r[63] ? 64'(-pr_r) : 64'(pr_r);
    ri_abs = pi_r[63] ? 64'(-pi_r) : 64'(pi_r);
    rm_sum = rm_abs + 64'd536870912;
    ri_sum = ri_abs + 64'd536870912;
    rm_q   = rm_sum[62:30];
    ri_q   = ri_sum[62:30];
    rnd_side_nxt     = mul_side_r;
    rnd_side_nxt.res = pr_r[63] ? -$signed(rm_q) : $signed(rm_q);
    if (mul_side_r.kind == ir2r_pkg::KIND_RESISTOR) begin
      rnd_side_nxt.stray = pi_r[63] ? -$signed(ri_q) : $signed(ri_q);
    end else begin
      rnd_side_nxt.stray = '0;
    end
    if (mul_side_r.kind == ir2r_pkg::KIND_INDUCTOR) begin
      rnd_side_nxt.wrong = pi_r[63];
      opb_nxt            = ir2r_pkg::IND_SCALE;
    end else begin
      rnd_side_nxt.wrong = !pi_r[63] && (pi_r != 64'sd0);
      opb_nxt            = 64'(den_r);
    end
    ap_nxt = ri_abs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      rnd_v_r <= 1'b0;
    end else if (adv) begin
      mul_v_r <= cor_v;
      rnd_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_side_r <= cor_side;
      pr_r       <= pr_nxt;
      pi_r       <= pi_nxt;
      rnd_side_r <= rnd_side_nxt;
      ap_r       <= ap_nxt;
      opb_r      <= opb_nxt;
    end
  end

  logic            m64_v;
  ir2r_pkg::side_t m64_side;
  logic [127:0]    m64_prod;

  ir2r_mul64 u_mul64 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (rnd_v_r),
    .in_side   (rnd_side_r),
    .in_a      (ap_r),
    .in_b      (opb_r),
    .out_valid (m64_v),
    .out_side  (m64_side),
    .out_prod  (m64_prod)
  );

  // Numerator and divisor, plus half the divisor for round half up.
  logic            prep_v_r;
  ir2r_pkg::side_t prep_side_r, prep_side_nxt;
  logic [127:0]    nh_r, nh_nxt, d_r, d_nxt, n_sel;

  always_comb begin
    if (m64_side.kind == ir2r_pkg::KIND_INDUCTOR) begin
      n_sel = m64_prod;
      d_nxt = 128'(den_r);
    end else begin
      n_sel = {ir2r_pkg::CAP_NUM_HI, 64'b0};
      d_nxt = m64_prod;
    end
    nh_nxt             = n_sel + {1'b0, d_nxt[127:1]};
    prep_side_nxt      = m64_side;
    prep_side_nxt.zero = (d_nxt == 128'd0);
  end

  // Quotient of 2^64 or more is caught before the divider.
  logic            ovf_v_r;
  ir2r_pkg::side_t ovf_side_r, ovf_side_nxt;
  logic [127:0]    onh_r;
  logic [DW-1:0]   od_r;

  always_comb begin
    ovf_side_nxt     = prep_side_r;
    ovf_side_nxt.ovf = ({64'b0, nh_r[127:64]} >= d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
      ovf_v_r  <= 1'b0;
    end else if (adv) begin
      prep_v_r <= m64_v;
      ovf_v_r  <= prep_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_side_r <= prep_side_nxt;
      nh_r        <= nh_nxt;
      d_r         <= d_nxt;
      ovf_side_r  <= ovf_side_nxt;
      onh_r       <= nh_r;
      od_r        <= d_r[DW-1:0];
    end
  end

  logic            div_v;
  ir2r_pkg::side_t div_side;
  logic [63:0]     div_quo;

  ir2r_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (ovf_v_r),
    .in_side   (ovf_side_r),
    .in_num    (onh_r),
    .in_den    (od_r),
    .out_valid (div_v),
    .out_side  (div_side),
    .out_quo   (div_quo)
  );

  // Output register with the saturation rules applied.
  logic               out_v_r;
  logic [1:0]         kind_r;
  logic signed [32:0] res_r, stray_r;
  logic [63:0]        value_r, value_nxt;
  logic               sat_r, sat_nxt;

  always_comb begin
    if (div_side.kind == ir2r_pkg::KIND_RESISTOR) begin
      value_nxt = '0;
      sat_nxt   = 1'b0;
    end else if (div_side.zero) begin
      value_nxt = '1;
      sat_nxt   = 1'b1;
    end else if (div_side.wrong) begin
      value_nxt = '0;
      sat_nxt   = 1'b1;
    end else if (div_side.ovf) begin
      value_nxt = '1;
      sat_nxt   = 1'b1;
    end else begin
      value_nxt = div_quo;
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r  <= div_side.kind;
      res_r   <= div_side.res;
      stray_r <= div_side.stray;
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_component_kind    = kind_r;
  assign out_series_resistance = res_r;
  assign out_stray_reactance   = stray_r;
  assign out_reactive_value    = value_r;
  assign out_value_saturated   = sat_r;

`ifndef SYNTHESIS
  a_res_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_component_kind == ir2r_pkg::KIND_RESISTOR)
      |-> (!out_value_saturated && out_reactive_value == 64'd0))
    else $error("resistor result carries a reactive value");

  a_reactive_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_component_kind != ir2r_pkg::KIND_RESISTOR)
      |-> (out_stray_reactance == 33'sd0))
    else $error("reactive part result carries stray reactance");

  a_stall_only_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");
`endif

endmodule

`default_nettype wire
